// ----- rtl/core/mpg_pkg.sv -----
// Shared types and constants for the muscle pulse gesture classifier.
`timescale 1ns / 1ps

package mpg_pkg;

	localparam int TIME_BITS     = 32;
	localparam int NOW_BITS      = 32;
	localparam int CFG_BITS      = 32;
	localparam int CFG_IDX_BITS  = 2;
	localparam int GESTURE_BITS  = 3;

	localparam logic [CFG_BITS-1:0] DOUBLE_WINDOW_RST = 32'd400;
	localparam logic [CFG_BITS-1:0] SINGLE_MIN_RST    = 32'd80;
	localparam logic [CFG_BITS-1:0] LONG_HOLD_RST     = 32'd1000;
	localparam logic [CFG_BITS-1:0] RELAX_RST         = 32'd2000;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_DOUBLE_WINDOW = 2'd0,
		CFG_SINGLE_MIN    = 2'd1,
		CFG_LONG_HOLD     = 2'd2,
		CFG_RELAX         = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE        = 2'd0,
		PH_CONTRACTION = 2'd1,
		PH_AFTER       = 2'd2,
		PH_HOLD_FIRED  = 2'd3
	} phase_t;

	typedef enum logic [GESTURE_BITS-1:0] {
		GEST_NONE      = 3'd0,
		GEST_RELAX     = 3'd1,
		GEST_LONG_HOLD = 3'd2,
		GEST_DOUBLE    = 3'd3,
		GEST_SINGLE    = 3'd4
	} gesture_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] double_window;
		logic [CFG_BITS-1:0] single_min;
		logic [CFG_BITS-1:0] hold_limit;
		logic [CFG_BITS-1:0] relax;
	} cfg_t;

endpackage

// ----- rtl/core/mpg_in_if.sv -----
// Sample channel: valid/ready with muscle flag and timestamp.
`timescale 1ns / 1ps

interface mpg_in_if;
	logic                          valid;
	logic                          ready;
	logic                          muscle_active;
	logic [mpg_pkg::NOW_BITS-1:0]  now_ms;

	modport source (output valid, output muscle_active, output now_ms, input ready);
	modport sink   (input valid, input muscle_active, input now_ms, output ready);
endinterface

// ----- rtl/core/mpg_out_if.sv -----
// Gesture channel: valid/ready with the reported gesture code.
`timescale 1ns / 1ps

interface mpg_out_if;
	logic                             valid;
	logic                             ready;
	logic [mpg_pkg::GESTURE_BITS-1:0] gesture;

	modport source (output valid, output gesture, input ready);
	modport sink   (input valid, input gesture, output ready);
endinterface

// ----- rtl/core/muscle_pulse_gesture_classifier_unit.sv -----
// Top level of the muscle pulse gesture classifier.
`timescale 1ns / 1ps

// Muscle pulse gesture classifier. Each transfer on the sample channel carries
// a muscle-active flag and a millisecond timestamp; each sample produces
// exactly one transfer on the result channel with a gesture code (none, relax,
// long hold, double contraction, single contraction), in sample order. The
// block takes one sample per clock cycle while the result channel does not
// stall: the sample is captured in an input register, classified from it by
// the state machine in one step, and the code is held in an output register,
// from which the result is offered. The rate is set by the state update loop
// (phase and timestamps feed the next sample's step). Back-pressure on the
// result channel stalls the input register and then the sample channel.
// Elapsed times wrap modulo 2^TIME_BITS; timestamps wider than the 32-bit
// sample field are zero-extended. Writing any configuration register puts
// the machine back to idle and zeroes both timestamps; write configuration
// only while no sample is in flight.
module muscle_pulse_gesture_classifier_unit #(
	parameter int TIME_BITS = mpg_pkg::TIME_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	mpg_in_if.sink                            sample,
	mpg_out_if.source                         result,
	input  logic                              cfg_we,
	input  logic [mpg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [mpg_pkg::CFG_BITS-1:0]      cfg_wdata
);

	mpg_pkg::cfg_t                 cfg;
	logic                          clear;

	// input stage
	logic                          valid_s1;
	logic                          active_s1;
	logic [mpg_pkg::NOW_BITS-1:0]  now_s1;

	// output stage
	logic                          valid_s2;
	mpg_pkg::gesture_t             gesture_s2;

	mpg_pkg::gesture_t             gesture_c;
	logic                          advance;
	logic                          take;

	// classify the held sample when the output register is free or draining
	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance;
	assign take         = sample.valid && sample.ready;

	mpg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg),
		.clear     (clear)
	);

	mpg_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (clear),
		.step    (advance),
		.active  (active_s1),
		.now_ms  (now_s1),
		.cfg     (cfg),
		.gesture (gesture_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (take) begin
			active_s1 <= sample.muscle_active;
			now_s1    <= sample.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gesture_s2 <= gesture_c;
		end
	end

	assign result.valid   = valid_s2;
	assign result.gesture = gesture_s2;

	a_step_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("classified sample did not reach the output register");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(now_s1) && $stable(active_s1)))
		else $error("stalled sample lost from the input register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !result.ready) |-> !advance)
		else $error("output register overwritten while stalled");

endmodule

// ----- rtl/core/mpg_cfg_regs.sv -----
// Configuration register file; any valid write also requests a machine clear.
`timescale 1ns / 1ps

module mpg_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mpg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [mpg_pkg::CFG_BITS-1:0]      cfg_wdata,
	output mpg_pkg::cfg_t                     cfg,
	output logic                              clear
);

	mpg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.double_window <= mpg_pkg::DOUBLE_WINDOW_RST;
			cfg_q.single_min    <= mpg_pkg::SINGLE_MIN_RST;
			cfg_q.hold_limit    <= mpg_pkg::LONG_HOLD_RST;
			cfg_q.relax         <= mpg_pkg::RELAX_RST;
		end else if (cfg_we) begin
			case (mpg_pkg::cfg_idx_t'(cfg_index))
				mpg_pkg::CFG_DOUBLE_WINDOW: cfg_q.double_window <= cfg_wdata;
				mpg_pkg::CFG_SINGLE_MIN:    cfg_q.single_min    <= cfg_wdata;
				mpg_pkg::CFG_LONG_HOLD:     cfg_q.hold_limit    <= cfg_wdata;
				mpg_pkg::CFG_RELAX:         cfg_q.relax         <= cfg_wdata;
				default:                    cfg_q               <= cfg_q;
			endcase
		end
	end

	// every index of the 2-bit port names a register
	assign clear = cfg_we;
	assign cfg   = cfg_q;

endmodule

// ----- rtl/core/mpg_core.sv -----
// Gesture state machine: phase, entry, last relax time; one step per cycle on step.
`timescale 1ns / 1ps

module mpg_core #(
	parameter int TIME_BITS = mpg_pkg::TIME_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                clear,
	input  logic                                step,
	input  logic                                active,
	input  logic [mpg_pkg::NOW_BITS-1:0]        now_ms,
	input  mpg_pkg::cfg_t                       cfg,
	output mpg_pkg::gesture_t                   gesture
);

	// compare width: elapsed times and 32-bit limits, both zero-extended
	localparam int CMP_BITS = (TIME_BITS > mpg_pkg::CFG_BITS) ? TIME_BITS : mpg_pkg::CFG_BITS;

	mpg_pkg::phase_t        phase_q, phase_d;
	logic [TIME_BITS-1:0]   entry_q, entry_d;
	logic [TIME_BITS-1:0]   relax_t_q, relax_t_d;

	logic [TIME_BITS-1:0]   now_t;
	logic [TIME_BITS-1:0]   elapsed;
	logic [TIME_BITS-1:0]   since_relax;
	logic [CMP_BITS-1:0]    el_x, sr_x;
	logic                   ge_relax, sr_ge_relax, ge_min, ge_hold, le_win, ge_win;

	assign now_t       = TIME_BITS'(now_ms);
	assign elapsed     = now_t - entry_q;
	assign since_relax = now_t - relax_t_q;
	assign el_x        = CMP_BITS'(elapsed);
	assign sr_x        = CMP_BITS'(since_relax);

	assign ge_relax    = el_x >= CMP_BITS'(cfg.relax);
	assign sr_ge_relax = sr_x >= CMP_BITS'(cfg.relax);
	assign ge_min      = el_x >= CMP_BITS'(cfg.single_min);
	assign ge_hold     = el_x >= CMP_BITS'(cfg.hold_limit);
	assign le_win      = el_x <= CMP_BITS'(cfg.double_window);
	assign ge_win      = el_x >= CMP_BITS'(cfg.double_window);

	always_comb begin
		phase_d   = phase_q;
		entry_d   = entry_q;
		relax_t_d = relax_t_q;
		gesture   = mpg_pkg::GEST_NONE;
		case (phase_q)
			mpg_pkg::PH_IDLE: begin
				if (active) begin
					phase_d = mpg_pkg::PH_CONTRACTION;
					entry_d = now_t;
				end else if (ge_relax && sr_ge_relax) begin
					relax_t_d = now_t;
					gesture   = mpg_pkg::GEST_RELAX;
				end
			end
			mpg_pkg::PH_CONTRACTION: begin
				if (!active) begin
					// short pulse is a glitch: back to idle, no report
					phase_d = ge_min ? mpg_pkg::PH_AFTER : mpg_pkg::PH_IDLE;
					entry_d = now_t;
				end else if (ge_hold) begin
					phase_d = mpg_pkg::PH_HOLD_FIRED;
					entry_d = now_t;
					gesture = mpg_pkg::GEST_LONG_HOLD;
				end
			end
			mpg_pkg::PH_AFTER: begin
				if (active) begin
					if (le_win)
						gesture = mpg_pkg::GEST_DOUBLE;
					phase_d = mpg_pkg::PH_CONTRACTION;
					entry_d = now_t;
				end else if (ge_win) begin
					phase_d = mpg_pkg::PH_IDLE;
					entry_d = now_t;
					gesture = mpg_pkg::GEST_SINGLE;
				end
			end
			mpg_pkg::PH_HOLD_FIRED: begin
				if (!active) begin
					phase_d = mpg_pkg::PH_IDLE;
					entry_d = now_t;
				end
			end
			default: begin
				phase_d = mpg_pkg::PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= mpg_pkg::PH_IDLE;
			entry_q   <= '0;
			relax_t_q <= '0;
		end else if (clear) begin
			phase_q   <= mpg_pkg::PH_IDLE;
			entry_q   <= '0;
			relax_t_q <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			entry_q   <= entry_d;
			relax_t_q <= relax_t_d;
		end
	end

	a_idle_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !clear && phase_q == mpg_pkg::PH_IDLE) |=>
		(phase_q == mpg_pkg::PH_IDLE || phase_q == mpg_pkg::PH_CONTRACTION))
		else $error("idle left for a phase other than contraction");

	a_hold_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == mpg_pkg::PH_HOLD_FIRED) |-> (gesture == mpg_pkg::GEST_NONE))
		else $error("gesture reported while long hold is latched");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (phase_q == mpg_pkg::PH_IDLE && entry_q == '0 && relax_t_q == '0))
		else $error("config write did not clear the machine");

	a_relax_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !clear && gesture == mpg_pkg::GEST_RELAX) |=> (relax_t_q == $past(now_t)))
		else $error("relax reported without stamping its time");

endmodule

// ----- test/tb_muscle_pulse_gesture_classifier_unit.sv -----
// Self-checking testbench for the muscle pulse gesture classifier top level.
`timescale 1ns / 1ps

module tb_muscle_pulse_gesture_classifier_unit;

	import mpg_pkg::*;

	// ------------------------------------------------------------------
	// Clock, reset and block inputs
	// ------------------------------------------------------------------
	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0]     cfg_wdata;

	mpg_in_if  sample_ch ();
	mpg_out_if result_ch ();

	muscle_pulse_gesture_classifier_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Gesture predictor: its own copy of registers and machine state
	// ------------------------------------------------------------------
	logic [CFG_BITS-1:0]  win_ms;       // double contraction window
	logic [CFG_BITS-1:0]  min_ms;       // glitch threshold
	logic [CFG_BITS-1:0]  hold_ms;      // long hold threshold
	logic [CFG_BITS-1:0]  relax_lim;    // relax idle time and repeat interval
	phase_t               ph_state;
	logic [TIME_BITS-1:0] ph_entry;
	logic [TIME_BITS-1:0] last_relax;

	gesture_t expected_gestures[$];     // one entry per accepted sample
	int       gestures_seen;
	int       mismatches;
	bit       rx_stall_on;              // receiver may stall in bursts

	// Random stimulus cursor: timestamp and the current pulse run
	logic [TIME_BITS-1:0] now_cursor;
	logic                 active_cur;
	int                   run_left;

	function automatic void clear_gesture_state();
		ph_state   = PH_IDLE;
		ph_entry   = '0;
		last_relax = '0;
	endfunction

	function automatic void apply_cfg(cfg_idx_t idx, logic [CFG_BITS-1:0] val);
		case (idx)
			CFG_DOUBLE_WINDOW: win_ms    = val;
			CFG_SINGLE_MIN:    min_ms    = val;
			CFG_LONG_HOLD:     hold_ms   = val;
			default:           relax_lim = val;
		endcase
		// any register write sends the machine back to idle
		clear_gesture_state();
	endfunction

	// One step of the classifier: returns the gesture, advances the state.
	function automatic gesture_t classify_sample(input logic active,
		input logic [TIME_BITS-1:0] now);
		logic [TIME_BITS-1:0] elapsed;
		logic [TIME_BITS-1:0] since_relax;
		gesture_t             g;
		elapsed     = now - ph_entry;
		since_relax = now - last_relax;
		g           = GEST_NONE;
		case (ph_state)
			PH_IDLE: begin
				if (active) begin
					ph_state = PH_CONTRACTION;
					ph_entry = now;
				end else if (elapsed >= relax_lim && since_relax >= relax_lim) begin
					last_relax = now;
					g          = GEST_RELAX;
				end
			end
			PH_CONTRACTION: begin
				if (!active) begin
					// short pulses are glitches and go straight back to idle
					ph_state = (elapsed >= min_ms) ? PH_AFTER : PH_IDLE;
					ph_entry = now;
				end else if (elapsed >= hold_ms) begin
					ph_state = PH_HOLD_FIRED;
					ph_entry = now;
					g        = GEST_LONG_HOLD;
				end
			end
			PH_AFTER: begin
				if (active) begin
					// a late second pulse just starts a new contraction
					if (elapsed <= win_ms)
						g = GEST_DOUBLE;
					ph_state = PH_CONTRACTION;
					ph_entry = now;
				end else if (elapsed >= win_ms) begin
					ph_state = PH_IDLE;
					ph_entry = now;
					g        = GEST_SINGLE;
				end
			end
			default: begin
				if (!active) begin
					ph_state = PH_IDLE;
					ph_entry = now;
				end
			end
		endcase
		return g;
	endfunction

	// ------------------------------------------------------------------
	// Directed probes, default registers. Rows with checked = 0 take their
	// expectation from the predictor instead of the table.
	// ------------------------------------------------------------------
	typedef struct {
		logic                 active;
		logic [TIME_BITS-1:0] now;
		bit                   checked;
		gesture_t             gesture;
	} probe_row_t;

	probe_row_t probe_rows[25] = '{
		'{1'b0, 32'd0,          1'b1, GEST_NONE},      // out of reset, nothing yet
		'{1'b0, 32'd2000,       1'b1, GEST_RELAX},     // idle for exactly relax time
		'{1'b0, 32'd3000,       1'b0, GEST_NONE},      // relax repeat interval not met
		'{1'b1, 32'd4000,       1'b1, GEST_NONE},
		'{1'b0, 32'd4050,       1'b1, GEST_NONE},      // glitch pulse dropped
		'{1'b1, 32'd5000,       1'b1, GEST_NONE},
		'{1'b0, 32'd5100,       1'b1, GEST_NONE},
		'{1'b1, 32'd5300,       1'b1, GEST_DOUBLE},    // second pulse inside window
		'{1'b1, 32'd6300,       1'b1, GEST_LONG_HOLD}, // held exactly long hold time
		'{1'b1, 32'd9000,       1'b0, GEST_NONE},      // still held after firing
		'{1'b0, 32'd9100,       1'b1, GEST_NONE},
		'{1'b1, 32'd9200,       1'b1, GEST_NONE},
		'{1'b0, 32'd9300,       1'b0, GEST_NONE},
		'{1'b0, 32'd9700,       1'b1, GEST_SINGLE},    // window closes at its edge
		'{1'b1, 32'd9800,       1'b1, GEST_NONE},
		'{1'b0, 32'd9900,       1'b1, GEST_NONE},
		'{1'b1, 32'd10301,      1'b1, GEST_NONE},      // late second pulse
		'{1'b0, 32'd10400,      1'b1, GEST_NONE},
		'{1'b0, 32'd10500,      1'b0, GEST_NONE},
		'{1'b0, 32'd10800,      1'b1, GEST_SINGLE},
		'{1'b0, 32'd5,          1'b1, GEST_RELAX},     // time runs backwards
		'{1'b1, 32'hFFFF_FFF0,  1'b1, GEST_NONE},
		'{1'b0, 32'h0000_0050,  1'b1, GEST_NONE},      // pulse spans the wrap
		'{1'b1, 32'hFFFF_FFFF,  1'b1, GEST_NONE},
		'{1'b0, 32'd0,          1'b1, GEST_NONE}
	};

	// ------------------------------------------------------------------
	// Sample channel driver: drives at negedge, sees the transfer at posedge
	// ------------------------------------------------------------------
	task automatic send_sample(input logic active, input logic [TIME_BITS-1:0] now,
		input bit checked, input gesture_t table_g, input bit idle_on);
		int       gap;
		gesture_t predicted;
		gap = 0;
		if (idle_on && $urandom_range(0, 9) == 0)
			gap = $urandom_range(1, 17);
		@(negedge clk);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid         <= 1'b1;
		sample_ch.muscle_active <= active;
		sample_ch.now_ms        <= now;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		// transfer taken: predict now, in acceptance order
		predicted = classify_sample(active, now);
		expected_gestures.push_back(checked ? table_g : predicted);
	endtask

	task automatic drop_valid();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Register writes, only with nothing in flight
	// ------------------------------------------------------------------
	task automatic write_cfg_all(input logic [CFG_BITS-1:0] w,
		input logic [CFG_BITS-1:0] m, input logic [CFG_BITS-1:0] h,
		input logic [CFG_BITS-1:0] r);
		cfg_idx_t             idx[4];
		logic [CFG_BITS-1:0]  val[4];
		idx = '{CFG_DOUBLE_WINDOW, CFG_SINGLE_MIN, CFG_LONG_HOLD, CFG_RELAX};
		val = '{w, m, h, r};
		while (expected_gestures.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);  // let the pipeline drain
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= val[i];
			apply_cfg(idx[i], val[i]);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Register value near the interesting corners, or a modest random one.
	function automatic logic [CFG_BITS-1:0] corner_value(input int lo, input int hi);
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return 32'd1;
			2:       return '1;
			3:       return 32'hFFFF_FFFE;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	// Time step sized against one of the thresholds, so that phases end on,
	// just before and just after their limits.
	function automatic logic [TIME_BITS-1:0] pick_step();
		logic [TIME_BITS-1:0] thr;
		int                   sel;
		case ($urandom_range(0, 3))
			0:       thr = win_ms;
			1:       thr = min_ms;
			2:       thr = hold_ms;
			default: thr = relax_lim;
		endcase
		sel = $urandom_range(0, 19);
		if (sel < 9)
			return thr + $urandom_range(0, 2) - 1;
		else if (sel < 13)
			return $urandom_range(0, thr >> 2);
		else if (sel < 16)
			return $urandom_range(0, 3);
		else if (sel < 19)
			return thr >> 1;
		else
			return $urandom();   // noise: arbitrary jump, often backwards
	endfunction

	// Mostly well formed pulse trains: runs of active / inactive samples.
	task automatic run_random(input int count, input bit idle_on);
		logic active;
		for (int n = 0; n < count; n++) begin
			if (run_left == 0) begin
				active_cur = ~active_cur;
				run_left   = $urandom_range(1, 4);
			end
			run_left--;
			now_cursor = now_cursor + pick_step();
			active     = ($urandom_range(0, 19) == 0) ? 1'($urandom()) : active_cur;
			send_sample(active, now_cursor, 1'b0, GEST_NONE, idle_on);
		end
		drop_valid();
	endtask

	// ------------------------------------------------------------------
	// Result channel: random stall bursts plus one long hold-off
	// ------------------------------------------------------------------
	initial begin : result_sink
		int stall_left;
		bit held_once;
		stall_left = 0;
		held_once  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_once && gestures_seen >= 500) begin
				// long back-pressure: the block fills and stops taking samples
				held_once          = 1'b1;
				result_ch.ready   <= 1'b0;
				repeat (199) @(negedge clk);
			end else if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (rx_stall_on && $urandom_range(0, 9) == 0) begin
				stall_left       = $urandom_range(1, 17) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each result transfer with the oldest prediction.
	always @(posedge clk) begin : gesture_check
		gesture_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			gestures_seen++;
			if (expected_gestures.size() == 0) begin
				$error("gesture: no result expected, got %0d", result_ch.gesture);
				mismatches++;
			end else begin
				want = expected_gestures.pop_front();
				if (result_ch.gesture !== want) begin
					$error("gesture: expected %0d, got %0d", want, result_ch.gesture);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_seq
		logic [CFG_BITS-1:0] w, m, h, r;

		arst_n                  = 1'b0;
		cfg_we                  = 1'b0;
		cfg_index               = CFG_DOUBLE_WINDOW;
		cfg_wdata               = '0;
		sample_ch.valid         = 1'b0;
		sample_ch.muscle_active = 1'b0;
		sample_ch.now_ms        = '0;
		result_ch.ready         = 1'b0;
		gestures_seen           = 0;
		mismatches              = 0;
		rx_stall_on             = 1'b1;
		now_cursor              = '0;
		active_cur              = 1'b0;
		run_left                = 0;

		// predictor starts from the reset register values
		win_ms    = DOUBLE_WINDOW_RST;
		min_ms    = SINGLE_MIN_RST;
		hold_ms   = LONG_HOLD_RST;
		relax_lim = RELAX_RST;
		clear_gesture_state();

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		foreach (probe_rows[i])
			send_sample(probe_rows[i].active, probe_rows[i].now, probe_rows[i].checked,
				probe_rows[i].gesture, 1'b1);
		run_random(200, 1'b1);

		// register settings: all zero, all ones, mixed corners, small random
		for (int p = 1; p <= 8; p++) begin
			case (p)
				1: begin w = '0; m = '0; h = '0; r = '0; end
				2: begin w = '1; m = '1; h = '1; r = '1; end
				3, 6: begin
					w = corner_value(1, 60);
					m = corner_value(1, 30);
					h = corner_value(10, 300);
					r = corner_value(20, 500);
				end
				default: begin
					w = $urandom_range(1, 60);
					m = $urandom_range(1, 30);
					h = $urandom_range(10, 300);
					r = $urandom_range(20, 500);
				end
			endcase
			if (p == 8)
				rx_stall_on = 1'b0;   // final stretch runs at full rate
			write_cfg_all(w, m, h, r);
			now_cursor = $urandom();
			run_random(220, p != 4 && p != 8);
		end

		// drain, then give stray results time to show up
		while (expected_gestures.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (expected_gestures.size() != 0) begin
			$error("gesture: %0d results never arrived", expected_gestures.size());
			mismatches++;
		end

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin : watchdog
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
